FILE: rtl/dci_pkg.sv
// ----------------------------------------------------------------------------
// dci_pkg
// Shared types and constants of the dipole calibration inversion unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dci_pkg;

    localparam int RAD_SHIFT  = 36;
    localparam int ROOT_SHIFT = 20;
    localparam int SQ_IN_W    = 84;
    localparam int SQ_ROOT_W  = 42;
    localparam int SQ_REM_W   = 46;
    localparam int SQ_STEPS   = 42;
    localparam int CNT_W      = 6;

    localparam logic signed [63:0] Q40_ONE   = 64'sh0000_0100_0000_0000;
    localparam logic signed [63:0] S64_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN   = 64'sh8000_0000_0000_0000;

    typedef enum logic [2:0]
    {
        REG_COEF_A  = 3'd0,
        REG_COEF_B  = 3'd1,
        REG_COEF_C  = 3'd2,
        REG_COEF_D  = 3'd3,
        REG_COEF_E  = 3'd4,
        REG_VOLTAGE = 3'd5,
        REG_OFFSET  = 3'd6,
        REG_UNUSED  = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0]
    {
        SH_FRAC = 2'd0,
        SH_RAD  = 2'd1,
        SH_ROOT = 2'd2
    } shift_t;

    typedef struct packed
    {
        logic               start;
        logic signed [63:0] a;
        logic signed [63:0] b;
        shift_t             sel;
    } mul_req_t;

    typedef struct packed
    {
        logic               done;
        logic signed [63:0] res;
    } mul_rsp_t;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] x,
                                                   input logic signed [63:0] y);
        logic signed [64:0] sum;
        sum = {x[63], x} + {y[63], y};
        if (sum[64] != sum[63])
        begin
            return sum[64] ? S64_MIN : S64_MAX;
        end
        return sum[63:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/dci_fifo.sv
// ----------------------------------------------------------------------------
// dci_fifo
// Two-entry queue of targets between the front and the bisection engine.
// ----------------------------------------------------------------------------
`default_nettype none

module dci_fifo
    import dci_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output      logic               push_ready,
    input  wire logic signed [63:0] push_data,
    output      logic               pop_valid,
    input  wire logic               pop,
    output      logic signed [63:0] pop_data
);

    logic signed [63:0] mem_reg [2];
    logic               wptr_reg, wptr_next;
    logic               rptr_reg, rptr_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_data   = mem_reg[rptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wptr_next = wptr_reg ^ do_push;
        rptr_next = rptr_reg ^ do_pop;
        cnt_next  = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dci_front.sv
// ----------------------------------------------------------------------------
// dci_front
// Input stage: takes a current beat and forms the Q.40 target.
// ----------------------------------------------------------------------------
`default_nettype none

module dci_front
    import dci_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire logic [31:0]        in_current,
    input  wire logic [31:0]        offset,
    output      logic               tgt_valid,
    input  wire logic               tgt_ready,
    output      logic signed [63:0] tgt_data
);

    logic               valid_reg, valid_next;
    logic signed [63:0] target_reg;
    logic signed [32:0] diff;

    assign in_ready  = !valid_reg || tgt_ready;
    assign tgt_valid = valid_reg;
    assign tgt_data  = target_reg;
    assign diff      = $signed({in_current[31], in_current}) - $signed({offset[31], offset});

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            target_reg <= {{7{diff[32]}}, diff, 24'd0};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dci_mul.sv
// ----------------------------------------------------------------------------
// dci_mul
// 64x64 signed multiply, shift right with floor rounding and saturation.
// Four 32x32 partial products are accumulated, then a finishing step shifts, rounds and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module dci_mul
    import dci_pkg::*;
#(
    parameter int FRAC_BITS = 20
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mul_req_t req,
    output      mul_rsp_t rsp
);

    logic [63:0]        mag_a_reg, mag_b_reg;
    logic               neg_reg;
    shift_t             sel_reg;
    logic [127:0]       acc_reg;
    logic [2:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic signed [63:0] res_reg;

    logic [31:0]        part_a, part_b;
    logic [63:0]        pp;
    logic [1:0]         offs;
    logic [127:0]       pp_ext;
    logic [6:0]         sh_amt;
    logic [127:0]       shifted, mask, mag;
    logic               rest, big;
    logic signed [63:0] fin;

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

    assign part_a = cnt_reg[1] ? mag_a_reg[63:32] : mag_a_reg[31:0];
    assign part_b = cnt_reg[0] ? mag_b_reg[63:32] : mag_b_reg[31:0];
    assign pp     = part_a * part_b;
    assign offs   = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
    assign pp_ext = {64'd0, pp} << {offs, 5'd0};

    always_comb
    begin
        case (sel_reg)
            SH_FRAC: sh_amt = 7'(FRAC_BITS);
            SH_RAD:  sh_amt = 7'(RAD_SHIFT);
            SH_ROOT: sh_amt = 7'(ROOT_SHIFT);
            default: sh_amt = 7'(FRAC_BITS);
        endcase
        shifted = acc_reg >> sh_amt;
        mask    = (128'd1 << sh_amt) - 128'd1;
        rest    = |(acc_reg & mask);
        mag     = shifted + {127'd0, neg_reg & rest};
        big     = |mag[127:63];
        if (neg_reg)
        begin
            fin = big ? S64_MIN : $signed(64'd0 - mag[63:0]);
        end
        else
        begin
            fin = big ? S64_MAX : $signed(mag[63:0]);
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 3'd0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd4)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mag_a_reg <= req.a[63] ? 64'd0 - req.a : req.a;
            mag_b_reg <= req.b[63] ? 64'd0 - req.b : req.b;
            neg_reg   <= req.a[63] ^ req.b[63];
            sel_reg   <= req.sel;
            acc_reg   <= 128'd0;
        end
        else if (busy_reg && cnt_reg != 3'd4)
        begin
            acc_reg <= acc_reg + pp_ext;
        end
        if (busy_reg && cnt_reg == 3'd4)
        begin
            res_reg <= fin;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dci_sqrt.sv
// ----------------------------------------------------------------------------
// dci_sqrt
// Digit-by-digit integer square root of r * 2^20, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dci_sqrt
    import dci_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [62:0]          radicand,
    output      logic                 done,
    output      logic [SQ_ROOT_W-1:0] root
);

    logic [SQ_IN_W-1:0]   x_reg;
    logic [SQ_REM_W-1:0]  rem_reg;
    logic [SQ_ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [SQ_REM_W-1:0]  rem_sh, trial;
    logic                 take;

    assign done   = done_reg;
    assign root   = root_reg;
    assign rem_sh = {rem_reg[SQ_REM_W-3:0], x_reg[SQ_IN_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign take   = rem_sh >= trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SQ_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= {1'b0, radicand, 20'd0};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= {x_reg[SQ_IN_W-3:0], 2'b00};
            rem_reg  <= take ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[SQ_ROOT_W-2:0], take};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dci_back.sv
// ----------------------------------------------------------------------------
// dci_back
// Bisection engine: evaluates the calibration current at each midpoint with
// the shared multiplier and square root unit, and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module dci_back
    import dci_pkg::*;
#(
    parameter int FRAC_BITS  = 20,
    parameter int SEARCH_MAX = 1000
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               tgt_valid,
    output      logic               tgt_pop,
    input  wire logic signed [63:0] tgt_data,
    input  wire logic signed [63:0] coef_a,
    input  wire logic signed [63:0] coef_b,
    input  wire logic signed [63:0] coef_c,
    input  wire logic signed [63:0] coef_d,
    input  wire logic signed [63:0] coef_e,
    input  wire logic [31:0]        accel_voltage,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic [29:0]        out_data
);

    localparam int BND_W = FRAC_BITS + 10;
    localparam logic [BND_W-1:0] LOW0  = BND_W'(1) << FRAC_BITS;
    localparam logic [BND_W-1:0] HIGH0 = BND_W'(SEARCH_MAX) << FRAC_BITS;

    typedef enum logic [5:0]
    {
        ST_IDLE = 6'b000001,
        ST_MID  = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_WAIT = 6'b001000,
        ST_ROOT = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    typedef enum logic [2:0]
    {
        PH_D   = 3'd0,
        PH_C   = 3'd1,
        PH_ONE = 3'd2,
        PH_P   = 3'd3,
        PH_R   = 3'd4,
        PH_I   = 3'd5
    } phase_t;

    state_t             state_reg, state_next;
    phase_t             ph_reg, ph_next;
    logic [BND_W-1:0]   lower_reg, lower_next;
    logic [BND_W-1:0]   upper_reg, upper_next;
    logic [BND_W-1:0]   mid_reg, mid_next;
    logic signed [63:0] t_reg, t_next;
    logic signed [63:0] target_reg, target_next;
    logic               out_valid_reg, out_valid_next;
    logic [29:0]        out_data_reg, out_data_next;

    logic [BND_W:0]        sum;
    logic [BND_W+29:0]     low_ext;
    logic signed [63:0]    m64, cur;
    mul_req_t              mul_req;
    mul_rsp_t              mul_rsp;
    logic                  sq_start, sq_done;
    logic [SQ_ROOT_W-1:0]  sq_root;

    dci_mul #(.FRAC_BITS(FRAC_BITS)) u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    dci_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (mul_rsp.res[62:0]),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign tgt_pop   = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign sum       = {1'b0, lower_reg} + {1'b0, upper_reg};
    assign low_ext   = {30'd0, lower_reg};
    assign m64       = {{(64-BND_W){1'b0}}, mid_reg};
    assign cur       = sat_add(coef_a, mul_rsp.res);

    always_comb
    begin
        mul_req.start = (state_reg == ST_MUL);
        mul_req.a     = (ph_reg == PH_I) ? coef_b : t_reg;
        mul_req.sel   = SH_FRAC;
        mul_req.b     = m64;
        if (ph_reg == PH_R)
        begin
            mul_req.b   = {32'd0, accel_voltage};
            mul_req.sel = SH_RAD;
        end
        else if (ph_reg == PH_I)
        begin
            mul_req.b   = t_reg;
            mul_req.sel = SH_ROOT;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ph_next        = ph_reg;
        lower_next     = lower_reg;
        upper_next     = upper_reg;
        mid_next       = mid_reg;
        t_next         = t_reg;
        target_next    = target_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        sq_start       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (tgt_valid)
                begin
                    target_next = tgt_data;
                    lower_next  = LOW0;
                    upper_next  = HIGH0;
                    state_next  = ST_MID;
                end
            end
            ST_MID:
            begin
                if (upper_reg - lower_reg > BND_W'(1))
                begin
                    mid_next   = sum[BND_W:1];
                    t_next     = coef_e;
                    ph_next    = PH_D;
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_MUL:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    state_next = ST_MUL;
                    case (ph_reg)
                        PH_D:
                        begin
                            t_next  = sat_add(coef_d, mul_rsp.res);
                            ph_next = PH_C;
                        end
                        PH_C:
                        begin
                            t_next  = sat_add(coef_c, mul_rsp.res);
                            ph_next = PH_ONE;
                        end
                        PH_ONE:
                        begin
                            t_next  = sat_add(Q40_ONE, mul_rsp.res);
                            ph_next = PH_P;
                        end
                        PH_P:
                        begin
                            t_next  = mul_rsp.res;
                            ph_next = PH_R;
                        end
                        PH_R:
                        begin
                            if (mul_rsp.res[63])
                            begin
                                lower_next = mid_reg;
                                state_next = ST_MID;
                            end
                            else
                            begin
                                sq_start   = 1'b1;
                                state_next = ST_ROOT;
                            end
                        end
                        PH_I:
                        begin
                            if (cur >= target_reg)
                            begin
                                upper_next = mid_reg;
                            end
                            else
                            begin
                                lower_next = mid_reg;
                            end
                            state_next = ST_MID;
                        end
                        default:
                        begin
                            state_next = ST_MID;
                        end
                    endcase
                end
            end
            ST_ROOT:
            begin
                if (sq_done)
                begin
                    t_next     = {{(64-SQ_ROOT_W){1'b0}}, sq_root};
                    ph_next    = PH_I;
                    state_next = ST_MUL;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = low_ext[29:0];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ph_reg        <= PH_D;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lower_reg    <= lower_next;
        upper_reg    <= upper_next;
        mid_reg      <= mid_next;
        t_reg        <= t_next;
        target_reg   <= target_next;
        out_data_reg <= out_data_next;
    end

`ifndef NO_ASSERTIONS
    a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (lower_reg < upper_reg))
        else $error("bisection bounds out of order");

    a_mul_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == ST_WAIT))
        else $error("multiplier result with no pending request");

    a_root_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> (state_reg == ST_ROOT))
        else $error("square root result with no pending request");

    a_mid_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (mid_reg > lower_reg && mid_reg < upper_reg))
        else $error("midpoint outside the interval");
`endif

endmodule

`default_nettype wire

FILE: rtl/dipole_calibration_inversion_unit.sv
// ----------------------------------------------------------------------------
// dipole_calibration_inversion_unit
// Inverts the dipole calibration I(m) = A + B*sqrt(V*(m+Cm^2+Dm^3+Em^4)) by
// bisection over m in [1, SEARCH_MAX].
// ----------------------------------------------------------------------------
// Each current beat yields one mass-to-charge beat, the lower bisection bound
// with FRAC_BITS fraction bits. About FRAC_BITS+10 halvings are done per item;
// each halving runs six multiplies on one shared 32x32 multiplier, a square
// root and a sequencing step, or only five multiplies when the radicand is
// negative. A new target is popped only when the engine is idle. Three targets
// queue ahead of the engine (the input register and a two-entry queue) and a
// finished result waits in an output register. Write the coefficient registers
// only while no item is in flight.
`default_nettype none

module dipole_calibration_inversion_unit
    import dci_pkg::*;
#(
    parameter int FRAC_BITS  = 20,
    parameter int SEARCH_MAX = 1000
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] dipole_current
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [31:0] m_axis_tdata,   // [29:0] mass_per_charge, [31:30] zero
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    logic signed [63:0] coef_a_reg, coef_b_reg, coef_c_reg, coef_d_reg, coef_e_reg;
    logic [31:0]        volt_reg, off_reg;

    logic               f_valid, f_ready, q_valid, q_pop;
    logic signed [63:0] f_data, q_data;
    logic [29:0]        res_data;

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = {2'b00, res_data};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg <= '0;
            coef_b_reg <= '0;
            coef_c_reg <= '0;
            coef_d_reg <= '0;
            coef_e_reg <= '0;
            volt_reg   <= '0;
            off_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_COEF_A:  coef_a_reg <= cfg_data;
                REG_COEF_B:  coef_b_reg <= cfg_data;
                REG_COEF_C:  coef_c_reg <= cfg_data;
                REG_COEF_D:  coef_d_reg <= cfg_data;
                REG_COEF_E:  coef_e_reg <= cfg_data;
                REG_VOLTAGE: volt_reg   <= cfg_data[31:0];
                REG_OFFSET:  off_reg    <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    dci_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_current (s_axis_tdata),
        .offset     (off_reg),
        .tgt_valid  (f_valid),
        .tgt_ready  (f_ready),
        .tgt_data   (f_data)
    );

    dci_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data)
    );

    dci_back #(.FRAC_BITS(FRAC_BITS), .SEARCH_MAX(SEARCH_MAX)) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .tgt_valid     (q_valid),
        .tgt_pop       (q_pop),
        .tgt_data      (q_data),
        .coef_a        (coef_a_reg),
        .coef_b        (coef_b_reg),
        .coef_c        (coef_c_reg),
        .coef_d        (coef_d_reg),
        .coef_e        (coef_e_reg),
        .accel_voltage (volt_reg),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_data      (res_data)
    );

endmodule

`default_nettype wire
